### hw/rtl/format_specifier_scanner_macros.svh
// Assertion macros for the format specifier scanner.
// Used by RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef FORMAT_SPECIFIER_SCANNER_MACROS_SVH
`define FORMAT_SPECIFIER_SCANNER_MACROS_SVH

// Implication check sampled on clk, off during reset.
`define FSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition check sampled on clk, off during reset.
`define FSS_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

### hw/rtl/fss_pkg.sv
// Package for the format specifier scanner: result type, scan modes, character classes.
// No dependencies.
`default_nettype none

package fss_pkg;

    localparam int FSS_MAX_SPECS  = 32;
    localparam int FSS_TYPE_CHARS = 7;

    localparam int TYPE_BYTES = 7;
    localparam int TDATA_W    = 96;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_PERCENT = 3'd1;
    localparam logic [2:0] MODE_POSDIG  = 3'd2;
    localparam logic [2:0] MODE_FLAGS   = 3'd3;
    localparam logic [2:0] MODE_WIDTH   = 3'd4;
    localparam logic [2:0] MODE_PREC    = 3'd5;
    localparam logic [2:0] MODE_LENGTH  = 3'd6;
    localparam logic [2:0] MODE_STOPPED = 3'd7;

    localparam logic KIND_SPEC = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    typedef struct packed {
        logic                      kind;
        logic [5:0]                spec_number;
        logic [15:0]               start_offset;
        logic [7:0]                spec_length;
        logic                      positional;
        logic                      numeric;
        logic [2:0]                type_count;
        logic [8*TYPE_BYTES-1:0]   type_text;
    } fss_result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // - + space # 0 '
    function automatic logic is_flag(input logic [7:0] c);
        return c inside {8'h2D, 8'h2B, 8'h20, 8'h23, 8'h30, 8'h27};
    endfunction

    // h l L q j z t
    function automatic logic is_lenmod(input logic [7:0] c);
        return c inside {8'h68, 8'h6C, 8'h4C, 8'h71, 8'h6A, 8'h7A, 8'h74};
    endfunction

    // d i u f F e E g G a A
    function automatic logic is_numeric(input logic [7:0] c);
        return c inside {8'h64, 8'h69, 8'h75, 8'h66, 8'h46, 8'h65, 8'h45,
                         8'h67, 8'h47, 8'h61, 8'h41};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/format_specifier_scanner.sv
// Top level of the printf format specifier scanner: input register, scanner core,
// output register. Depends on fss_pkg, fss_core, fss_out_reg and the macros header.
//
//   channel   dir   tdata                        tuser
//   s_axis    in    char_in[7:0]                 -
//   m_axis    out   spec fields, 96 bits         kind
//
// One text byte per cycle sustained while m_axis does not stall; a byte's result
// passes from the input register into the output register. The core's state update
// is one short step per byte between the input register and the output register.
// rst_n clears the scanner state and both valid flags asynchronously.
// A stall on m_axis holds the byte in the input register; s_axis stalls only
// when that register and the output register are both full and m_axis_tready is low.
`default_nettype none
`include "format_specifier_scanner_macros.svh"

module format_specifier_scanner
    import fss_pkg::*;
#(
    parameter int MAX_SPECS  = FSS_MAX_SPECS,
    parameter int TYPE_CHARS = FSS_TYPE_CHARS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // [7:0] char_in
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [5:0] spec_number, [21:6] start_offset, [29:22] spec_length, [30] positional,
    // [31] numeric, [34:32] type_count, [90:35] type_text, [95:91] zero
    output logic [TDATA_W-1:0]       m_axis_tdata,
    output logic                     m_axis_tuser    // [0] kind
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        step;
    logic        free;
    logic        res_valid;
    fss_result_t res;
    fss_result_t out_data;

    assign step          = in_valid_reg && free;
    assign s_axis_tready = !in_valid_reg || step;
    assign in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    fss_core #(
        .MAX_SPECS  (MAX_SPECS),
        .TYPE_CHARS (TYPE_CHARS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_in   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    fss_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .load_data (res),
        .out_ready (m_axis_tready),
        .free      (free),
        .out_valid (m_axis_tvalid),
        .out_data  (out_data)
    );

    assign m_axis_tuser = out_data.kind;
    assign m_axis_tdata = {5'd0, out_data.type_text, out_data.type_count, out_data.numeric,
                           out_data.positional, out_data.spec_length,
                           out_data.start_offset, out_data.spec_number};

    `FSS_ASSERT(a_result_lands, step && res_valid |=> m_axis_tvalid, "result not registered")
    `FSS_ASSERT(a_hold_byte, in_valid_reg && !step |=> in_valid_reg && $stable(in_byte_reg),
                "input byte lost")
    `FSS_ASSERT(a_nul_ends, step && in_byte_reg == CH_NUL |-> res_valid && res.kind == KIND_END,
                "zero byte gave no end result")
    `FSS_CHECK(a_end_clean, !(m_axis_tvalid && m_axis_tuser) || m_axis_tdata[95:6] == '0,
               "end result carries spec fields")

endmodule

`default_nettype wire

### hw/rtl/fss_core.sv
// Scanner state and per-byte transition logic; emits at most one result per byte.
// Depends on fss_pkg.
`default_nettype none

module fss_core
    import fss_pkg::*;
#(
    parameter int MAX_SPECS  = FSS_MAX_SPECS,
    parameter int TYPE_CHARS = FSS_TYPE_CHARS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  char_in,
    output logic             res_valid,
    output fss_result_t      res
);

    logic [2:0]              mode_reg,   mode_next;
    logic [15:0]             offset_reg, offset_next;
    logic [15:0]             start_reg,  start_next;
    logic [7:0]              length_reg, length_next;
    logic [5:0]              count_reg,  count_next;
    logic                    pos_reg,    pos_next;
    logic                    ozd_reg,    ozd_next;
    logic [8*TYPE_BYTES-1:0] tbuf_reg,   tbuf_next;
    logic [2:0]              tfill_reg,  tfill_next;

    logic                    run_spec;
    logic                    clr_type;
    logic                    stay;
    logic [2:0]              spec_mode;
    logic [7:0]              length_sat;

    assign length_sat = (length_reg == 8'hFF) ? length_reg : length_reg + 8'd1;

    always_comb
    begin
        mode_next   = mode_reg;
        offset_next = offset_reg;
        start_next  = start_reg;
        length_next = length_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        ozd_next    = ozd_reg;
        tbuf_next   = tbuf_reg;
        tfill_next  = tfill_reg;
        run_spec    = 1'b0;
        clr_type    = 1'b0;
        stay        = 1'b0;
        spec_mode   = MODE_FLAGS;
        res_valid   = 1'b0;
        res         = '0;

        if (char_in == CH_NUL)
        begin
            res_valid       = 1'b1;
            res.kind        = KIND_END;
            res.spec_number = count_reg;
            mode_next       = MODE_IDLE;
            offset_next     = '0;
            start_next      = '0;
            length_next     = '0;
            count_next      = '0;
            pos_next        = 1'b0;
            ozd_next        = 1'b1;
            tbuf_next       = '0;
            tfill_next      = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (char_in == CH_PERCENT)
                    begin
                        start_next  = offset_reg;
                        length_next = 8'd1;
                        mode_next   = MODE_PERCENT;
                    end
                end
                MODE_PERCENT:
                begin
                    if (char_in == CH_PERCENT)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (count_reg >= 6'(MAX_SPECS))
                    begin
                        mode_next = MODE_STOPPED;
                    end
                    else
                    begin
                        pos_next    = 1'b0;
                        clr_type    = 1'b1;
                        length_next = length_sat;
                        if (is_digit(char_in))
                        begin
                            ozd_next  = (char_in == CH_ZERO);
                            mode_next = MODE_POSDIG;
                        end
                        else
                        begin
                            ozd_next  = 1'b1;
                            run_spec  = 1'b1;
                            spec_mode = MODE_FLAGS;
                        end
                    end
                end
                MODE_POSDIG:
                begin
                    length_next = length_sat;
                    if (is_digit(char_in))
                    begin
                        if (char_in != CH_ZERO)
                        begin
                            ozd_next = 1'b0;
                        end
                    end
                    else if (char_in == CH_DOLLAR)
                    begin
                        pos_next  = 1'b1;
                        mode_next = MODE_FLAGS;
                    end
                    else
                    begin
                        run_spec  = 1'b1;
                        spec_mode = ozd_reg ? MODE_FLAGS : MODE_WIDTH;
                    end
                end
                MODE_FLAGS, MODE_WIDTH, MODE_PREC, MODE_LENGTH:
                begin
                    length_next = length_sat;
                    run_spec    = 1'b1;
                    spec_mode   = mode_reg;
                end
                MODE_STOPPED:
                begin
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase

            if (offset_reg != 16'hFFFF)
            begin
                offset_next = offset_reg + 16'd1;
            end

            if (clr_type)
            begin
                tbuf_next  = '0;
                tfill_next = '0;
            end

            if (run_spec)
            begin
                if (spec_mode == MODE_FLAGS)
                begin
                    if (is_flag(char_in))
                        stay = 1'b1;
                    else
                        spec_mode = MODE_WIDTH;
                end
                if (!stay && spec_mode == MODE_WIDTH)
                begin
                    if (is_digit(char_in))
                    begin
                        stay = 1'b1;
                    end
                    else if (char_in == CH_DOT)
                    begin
                        spec_mode = MODE_PREC;
                        stay      = 1'b1;
                    end
                    else
                    begin
                        spec_mode = MODE_LENGTH;
                    end
                end
                else if (!stay && spec_mode == MODE_PREC)
                begin
                    if (is_digit(char_in))
                        stay = 1'b1;
                    else
                        spec_mode = MODE_LENGTH;
                end

                if (stay)
                begin
                    mode_next = spec_mode;
                end
                else
                begin
                    if (tfill_next < 3'(TYPE_CHARS))
                    begin
                        for (int k = 0; k < TYPE_BYTES; k++)
                        begin
                            if (tfill_next == 3'(k))
                                tbuf_next[8*k +: 8] = char_in;
                        end
                        tfill_next = tfill_next + 3'd1;
                    end
                    if (is_lenmod(char_in))
                    begin
                        mode_next = MODE_LENGTH;
                    end
                    else
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_SPEC;
                        res.spec_number  = count_reg;
                        res.start_offset = start_reg;
                        res.spec_length  = length_next;
                        res.positional   = pos_next;
                        res.numeric      = is_numeric(char_in);
                        res.type_count   = tfill_next;
                        res.type_text    = tbuf_next;
                        count_next       = count_reg + 6'd1;
                        mode_next        = MODE_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            offset_reg <= '0;
            start_reg  <= '0;
            length_reg <= '0;
            count_reg  <= '0;
            pos_reg    <= 1'b0;
            ozd_reg    <= 1'b1;
            tbuf_reg   <= '0;
            tfill_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            ozd_reg    <= ozd_next;
            tbuf_reg   <= tbuf_next;
            tfill_reg  <= tfill_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fss_out_reg.sv
// Output result register for the format specifier scanner.
// Depends on fss_pkg.
`default_nettype none

module fss_out_reg
    import fss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire fss_result_t load_data,
    input  wire logic        out_ready,
    output logic             free,
    output logic             out_valid,
    output fss_result_t      out_data
);

    logic        valid_reg, valid_next;
    fss_result_t data_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

endmodule

`default_nettype wire

### tb/fss_spec_checker.sv
// Checker for the format specifier scanner: watches both stream channels, predicts each
// result beat from the accepted text bytes and compares it field by field.
// Depends on fss_pkg for the result type, scan modes, kinds and character codes.
`timescale 1ns / 100ps

module fss_spec_checker
    import fss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [TDATA_W-1:0]  m_axis_tdata,
    input  logic                m_axis_tuser,
    output int                  mismatches,
    output int                  pending
);

    fss_result_t spec_q[$];

    logic [2:0]  mode;
    logic [15:0] offs;
    logic [15:0] spec_start;
    logic [7:0]  spec_len;
    logic [5:0]  n_found;
    logic        pos_mark;
    logic        zeros_only;
    logic [55:0] mods;
    logic [2:0]  mod_fill;

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic bit dec_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit flag_char(input logic [7:0] c);
        case (c)
            "-", "+", " ", "#", "0", "'": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit len_char(input logic [7:0] c);
        case (c)
            "h", "l", "L", "q", "j", "z", "t": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit num_conv(input logic [7:0] c);
        case (c)
            "d", "i", "u", "f", "F", "e", "E", "g", "G", "a", "A": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void clear_scan();
        mode       = MODE_IDLE;
        offs       = '0;
        spec_start = '0;
        spec_len   = '0;
        n_found    = '0;
        pos_mark   = 1'b0;
        zeros_only = 1'b1;
        mods       = '0;
        mod_fill   = '0;
    endfunction

    function automatic void bump_len();
        if (spec_len != 8'hFF)
            spec_len = spec_len + 8'd1;
    endfunction

    // Flags, width, precision and length phases fall through in one byte.
    function automatic void take_spec_byte(input logic [7:0] c);
        fss_result_t r;
        if (mode == MODE_FLAGS)
        begin
            if (flag_char(c))
                return;
            mode = MODE_WIDTH;
        end
        if (mode == MODE_WIDTH)
        begin
            if (dec_digit(c))
                return;
            if (c == CH_DOT)
            begin
                mode = MODE_PREC;
                return;
            end
            mode = MODE_LENGTH;
        end
        if (mode == MODE_PREC)
        begin
            if (dec_digit(c))
                return;
            mode = MODE_LENGTH;
        end
        if (mod_fill < FSS_TYPE_CHARS && mod_fill < 3'd7)
        begin
            mods[8*mod_fill +: 8] = c;
            mod_fill = mod_fill + 3'd1;
        end
        if (len_char(c))
            return;
        r              = '0;
        r.kind         = KIND_SPEC;
        r.spec_number  = n_found;
        r.start_offset = spec_start;
        r.spec_length  = spec_len;
        r.positional   = pos_mark;
        r.numeric      = num_conv(c);
        r.type_count   = mod_fill;
        r.type_text    = mods;
        spec_q.push_back(r);
        n_found = n_found + 6'd1;
        mode    = MODE_IDLE;
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        fss_result_t r;
        if (c == CH_NUL)
        begin
            r             = '0;
            r.kind        = KIND_END;
            r.spec_number = n_found;
            spec_q.push_back(r);
            clear_scan();
            return;
        end
        case (mode)
            MODE_IDLE:
                if (c == CH_PERCENT)
                begin
                    spec_start = offs;
                    spec_len   = 8'd1;
                    mode       = MODE_PERCENT;
                end
            MODE_PERCENT:
                if (c == CH_PERCENT)
                    mode = MODE_IDLE;
                else if (n_found >= FSS_MAX_SPECS)
                    mode = MODE_STOPPED;
                else
                begin
                    pos_mark = 1'b0;
                    mods     = '0;
                    mod_fill = '0;
                    bump_len();
                    if (dec_digit(c))
                    begin
                        zeros_only = (c == CH_ZERO);
                        mode       = MODE_POSDIG;
                    end
                    else
                    begin
                        zeros_only = 1'b1;
                        mode       = MODE_FLAGS;
                        take_spec_byte(c);
                    end
                end
            MODE_POSDIG:
            begin
                bump_len();
                if (dec_digit(c))
                begin
                    if (c != CH_ZERO)
                        zeros_only = 1'b0;
                end
                else if (c == CH_DOLLAR)
                begin
                    pos_mark = 1'b1;
                    mode     = MODE_FLAGS;
                end
                else
                begin
                    // all-zero digits are zero flags, anything else is a width
                    mode = zeros_only ? MODE_FLAGS : MODE_WIDTH;
                    take_spec_byte(c);
                end
            end
            MODE_FLAGS, MODE_WIDTH, MODE_PREC, MODE_LENGTH:
            begin
                bump_len();
                take_spec_byte(c);
            end
            MODE_STOPPED:
                ;
            default:
                mode = MODE_IDLE;
        endcase
        if (offs != 16'hFFFF)
            offs = offs + 16'd1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        fss_result_t seen;
        fss_result_t want;
        if (!rst_n)
        begin
            clear_scan();
            spec_q.delete();
        end
        else
        begin
            // result beats first: a byte taken this edge cannot be the one reported
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.kind         = m_axis_tuser;
                seen.spec_number  = m_axis_tdata[5:0];
                seen.start_offset = m_axis_tdata[21:6];
                seen.spec_length  = m_axis_tdata[29:22];
                seen.positional   = m_axis_tdata[30];
                seen.numeric      = m_axis_tdata[31];
                seen.type_count   = m_axis_tdata[34:32];
                seen.type_text    = m_axis_tdata[90:35];
                if (spec_q.size() == 0)
                begin
                    $error("result beat with nothing expected: kind %0d spec_number %0d",
                           seen.kind, seen.spec_number);
                    mismatches++;
                end
                else
                begin
                    want = spec_q.pop_front();
                    check_field("kind", want.kind, seen.kind);
                    check_field("spec_number", want.spec_number, seen.spec_number);
                    check_field("start_offset", want.start_offset, seen.start_offset);
                    check_field("spec_length", want.spec_length, seen.spec_length);
                    check_field("positional", want.positional, seen.positional);
                    check_field("numeric", want.numeric, seen.numeric);
                    check_field("type_count", want.type_count, seen.type_count);
                    check_field("type_text", want.type_text, seen.type_text);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                scan_char(s_axis_tdata);
        end
        pending = spec_q.size();
    end

endmodule

### tb/format_specifier_scanner_tb.sv
// Testbench top for the format specifier scanner: clock, reset, text byte stimulus with
// random idling on both channels, and the verdict. Depends on fss_pkg,
// format_specifier_scanner and fss_spec_checker.
`timescale 1ns / 100ps

module format_specifier_scanner_tb;
    import fss_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;
    int                 mismatches;
    int                 pending;

    logic [7:0] text_q[$];
    bit         calm_tx;
    bit         calm_rx;
    int         random_bytes;

    format_specifier_scanner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fss_spec_checker spec_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stall before each beat, with calm stretches
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        calm_rx       = 1'b0;
        forever
        begin
            stall = calm_rx ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 63) == 0)
                calm_rx = ~calm_rx;
            repeat (stall)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 63) == 0)
            calm_tx = ~calm_tx;
        @(negedge clk);
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_text();
        int k;
        for (k = 0; k < text_q.size(); k++)
            send_char(text_q[k]);
        text_q.delete();
    endtask

    function automatic void queue_str(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            text_q.push_back(s[k]);
    endfunction

    function automatic logic [7:0] pick_from(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void add_digits(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n)
            text_q.push_back(pick_from("0123456789"));
    endfunction

    function automatic void add_plain(input int n);
        logic [7:0] c;
        repeat (n)
        begin
            c = 8'($urandom_range(1, 255));
            if (c == CH_PERCENT)
                c = "p";
            text_q.push_back(c);
        end
    endfunction

    function automatic void add_noise(input int n);
        repeat (n)
            text_q.push_back(8'($urandom_range(1, 255)));
    endfunction

    // percent, position, flags, width, precision, length modifiers, conversion
    function automatic void add_spec(input bit with_conv);
        int n;
        text_q.push_back(CH_PERCENT);
        if ($urandom_range(0, 3) == 0)
        begin
            add_digits(1, 3);
            text_q.push_back(CH_DOLLAR);
        end
        n = $urandom_range(0, 3);
        repeat (n)
            text_q.push_back(pick_from("-+ #0'"));
        add_digits(0, 3);
        if ($urandom_range(0, 2) == 0)
        begin
            text_q.push_back(CH_DOT);
            add_digits(0, 2);
        end
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 2);
        repeat (n)
            text_q.push_back(pick_from("hlLqjzt"));
        if (with_conv)
        begin
            case ($urandom_range(0, 2))
                0: text_q.push_back(pick_from("diufFeEgGaA"));
                1: text_q.push_back(pick_from("sxXcpnoS%"));
                default: text_q.push_back(8'($urandom_range(1, 255)));
            endcase
        end
    endfunction

    function automatic void add_long_spec(input int n_digits);
        text_q.push_back(CH_PERCENT);
        text_q.push_back(pick_from("123456789"));
        repeat (n_digits - 1)
            text_q.push_back(pick_from("0123456789"));
        text_q.push_back("d");
    endfunction

    function automatic void build_text();
        int segs;
        int sel;
        sel = $urandom_range(0, 39);
        if (sel < 3)
        begin
            // past the specifier limit
            repeat ($urandom_range(FSS_MAX_SPECS + 1, FSS_MAX_SPECS + 6))
            begin
                if ($urandom_range(0, 7) == 0)
                    queue_str("%%");
                text_q.push_back(CH_PERCENT);
                text_q.push_back(pick_from("diufFeEgGaAsxc"));
            end
            add_noise($urandom_range(0, 6));
        end
        else
        begin
            segs = $urandom_range(0, 6);
            repeat (segs)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 4)
                    add_plain($urandom_range(0, 5));
                else if (sel < 9)
                    add_spec(1'b1);
                else
                    add_noise($urandom_range(1, 6));
            end
            if ($urandom_range(0, 39) == 0)
                add_long_spec($urandom_range(250, 270));
            if ($urandom_range(0, 7) == 0)
                add_spec(1'b0);
        end
        text_q.push_back(CH_NUL);
    endfunction

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rst_n         = 1'b0;
        calm_tx       = 1'b0;
        random_bytes  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty text, every flag and length modifier with overflowing type store,
        // literal percent, zero flags vs width digits, dot without precision,
        // zero position with percent conversion, unfinished specifier, byte extremes
        text_q.push_back(CH_NUL);
        queue_str("%1$-+ #0'7.3hlLqjztd");
        text_q.push_back(CH_NUL);
        queue_str("a%%%00x%05.E%0$%%3.");
        text_q.push_back(CH_NUL);
        text_q.push_back(8'hFF);
        text_q.push_back(CH_PERCENT);
        text_q.push_back(8'h80);
        text_q.push_back(CH_PERCENT);
        text_q.push_back(8'h01);
        text_q.push_back(CH_NUL);
        send_text();

        // length saturation
        add_long_spec(270);
        queue_str("%-5s");
        text_q.push_back(CH_NUL);
        send_text();

        while (random_bytes < 1225)
        begin
            build_text();
            random_bytes += text_q.size();
            send_text();
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
